>>> design/whm_pkg.sv
// Shared types, constants and helper functions for the working-hours meter.
`timescale 1ns / 1ps
`default_nettype none

package whm_pkg;

    localparam int unsigned HOURS_W      = 32;
    localparam int unsigned MINS_W       = 11;
    localparam int unsigned TGT_W        = 3;
    localparam int unsigned CHK_W        = 8;
    localparam int unsigned NSLOT        = 4;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [MINS_W-1:0]  DAY_MINUTES = 11'd1440;
    localparam logic [HOURS_W-1:0] DAY_HOURS   = 32'd24;
    localparam logic [CHK_W-1:0]   CHECK_BIAS  = 8'hAA;
    localparam logic [CHK_W-1:0]   CLEAR_CHECK = 8'h57;

    // minutes / 60 as (m * 2185) >> 17, exact for every 11-bit count
    localparam logic [11:0] DIV60_MUL   = 12'd2185;
    localparam int unsigned DIV60_SHIFT = 17;
    localparam int unsigned PROD_W      = MINS_W + 12;

    localparam logic [TGT_W-1:0] TGT_SYS_HOURS  = 3'd0;
    localparam logic [TGT_W-1:0] TGT_SYS_EIGHTH = 3'd1;
    localparam logic [TGT_W-1:0] TGT_BL_HOURS   = 3'd2;
    localparam logic [TGT_W-1:0] TGT_BL_EIGHTH  = 3'd3;
    localparam logic [TGT_W-1:0] TGT_NONE       = 3'd4;

    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_RESTORE   = 2'd1,
        ACT_CLEAR_SYS = 2'd2,
        ACT_CLEAR_BL  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_SYS_HOURS  = 3'd0,
        REG_SYS_CHECK  = 3'd1,
        REG_SYS_EIGHTH = 3'd2,
        REG_BL_HOURS   = 3'd3,
        REG_BL_CHECK   = 3'd4,
        REG_BL_EIGHTH  = 3'd5
    } t_reg;

    // saved values read back from storage
    typedef struct packed {
        logic [HOURS_W-1:0] sys_hr;
        logic [CHK_W-1:0]   sys_check;
        logic [7:0]         sys_eighths;
        logic [HOURS_W-1:0] bl_hr;
        logic [CHK_W-1:0]   bl_check;
        logic [7:0]         bl_eighths;
    } t_saved;

    // one classified request: meter values after update and the writes due
    typedef struct packed {
        logic [HOURS_W-1:0] sys_hr;
        logic [MINS_W-1:0]  sys_min;
        logic [HOURS_W-1:0] bl_hr;
        logic [MINS_W-1:0]  bl_min;
        logic [NSLOT-1:0]   due;
        logic               clr;
    } t_job;

    function automatic logic [CHK_W-1:0] check_of(input logic [HOURS_W-1:0] h);
        logic [CHK_W-1:0] s;
        s = 8'd1 + h[7:0] + h[15:8] + h[23:16] + h[31:24];
        return s - CHECK_BIAS;
    endfunction

    function automatic logic [5:0] div60(input logic [MINS_W-1:0] m);
        logic [PROD_W-1:0] p;
        p = {{(PROD_W-MINS_W){1'b0}}, m} * {{(PROD_W-12){1'b0}}, DIV60_MUL};
        return p[DIV60_SHIFT +: 6];
    endfunction

endpackage

`default_nettype wire

>>> design/whm_queue.sv
// Short request queue between the classifying front and the result back end.
`timescale 1ns / 1ps
`default_nettype none

module whm_queue #(
    parameter int unsigned DEPTH = whm_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire whm_pkg::t_job i_data,
    input  wire logic          i_pop,
    output whm_pkg::t_job      o_data,
    output logic               o_full,
    output logic               o_empty
);
    import whm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // advance pointers with wrap at the queue depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // store the request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> design/whm_front.sv
// Front end: accepts requests, updates both meters and lists the writes due.
`timescale 1ns / 1ps
`default_nettype none

module whm_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_action,
    input  wire logic                           i_backlight_on,
    input  wire whm_pkg::t_saved                i_saved,
    input  wire logic                           i_queue_full,
    output logic                                o_push,
    output whm_pkg::t_job                       o_job
);
    import whm_pkg::*;

    logic [HOURS_W-1:0] r_sys_hr;
    logic [MINS_W-1:0]  r_sys_min;
    logic [HOURS_W-1:0] r_bl_hr;
    logic [MINS_W-1:0]  r_bl_min;

    logic [HOURS_W-1:0] n_sys_hr;
    logic [MINS_W-1:0]  n_sys_min;
    logic [HOURS_W-1:0] n_bl_hr;
    logic [MINS_W-1:0]  n_bl_min;

    logic [MINS_W-1:0]  sys_m1;
    logic [MINS_W-1:0]  bl_m1;
    logic               sys_roll;
    logic               bl_roll;
    logic [MINS_W-1:0]  sys_tick_m;
    logic [MINS_W-1:0]  bl_tick_m;
    logic [NSLOT-1:0]   due;
    logic               clr;
    t_action            act;

    assign act     = t_action'(i_action);
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && o_ready;

    // one minute step of each meter, with day rollover
    assign sys_m1     = r_sys_min + 1'b1;
    assign bl_m1      = r_bl_min + 1'b1;
    assign sys_roll   = (sys_m1 >= DAY_MINUTES);
    assign bl_roll    = (bl_m1 >= DAY_MINUTES);
    assign sys_tick_m = sys_roll ? '0 : sys_m1;
    assign bl_tick_m  = bl_roll ? '0 : bl_m1;

    // decode the action into new meter values and the writes it causes
    always_comb begin
        n_sys_hr  = r_sys_hr;
        n_sys_min = r_sys_min;
        n_bl_hr   = r_bl_hr;
        n_bl_min  = r_bl_min;
        due       = '0;
        clr       = 1'b0;
        unique case (act)
            ACT_TICK: begin
                n_sys_min = sys_tick_m;
                n_sys_hr  = sys_roll ? r_sys_hr + DAY_HOURS : r_sys_hr;
                due[0]    = sys_roll;
                due[1]    = (sys_tick_m[2:0] == 3'd0);
                if (i_backlight_on) begin
                    n_bl_min = bl_tick_m;
                    n_bl_hr  = bl_roll ? r_bl_hr + DAY_HOURS : r_bl_hr;
                    due[2]   = bl_roll;
                    due[3]   = (bl_tick_m[2:0] == 3'd0);
                end
            end
            ACT_RESTORE: begin
                n_sys_hr  = (check_of(i_saved.sys_hr) == i_saved.sys_check)
                            ? i_saved.sys_hr : '0;
                n_sys_min = {i_saved.sys_eighths, 3'b000};
                n_bl_hr   = (check_of(i_saved.bl_hr) == i_saved.bl_check)
                            ? i_saved.bl_hr : '0;
                n_bl_min  = {i_saved.bl_eighths, 3'b000};
            end
            ACT_CLEAR_SYS: begin
                n_sys_hr  = '0;
                n_sys_min = '0;
                due       = 4'b0011;
                clr       = 1'b1;
            end
            ACT_CLEAR_BL: begin
                n_bl_hr  = '0;
                n_bl_min = '0;
                due      = 4'b1100;
                clr      = 1'b1;
            end
            default: begin
                due = '0;
            end
        endcase
    end

    always_comb begin
        o_job.sys_hr  = n_sys_hr;
        o_job.sys_min = n_sys_min;
        o_job.bl_hr   = n_bl_hr;
        o_job.bl_min  = n_bl_min;
        o_job.due     = due;
        o_job.clr     = clr;
    end

    // commit meter state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_hr  <= '0;
            r_sys_min <= '0;
            r_bl_hr   <= '0;
            r_bl_min  <= '0;
        end else if (o_push) begin
            r_sys_hr  <= n_sys_hr;
            r_sys_min <= n_sys_min;
            r_bl_hr   <= n_bl_hr;
            r_bl_min  <= n_bl_min;
        end
    end

`ifndef SYNTHESIS
    a_clear_sys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && act == ACT_CLEAR_SYS) |=> (r_sys_hr == '0 && r_sys_min == '0))
        else $error("system meter not cleared");
`endif

endmodule

`default_nettype wire

>>> design/whm_back.sv
// Back end: issues the writes of each queued request one per cycle while the result output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module whm_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire whm_pkg::t_job                  i_job,
    input  wire logic                           i_queue_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [whm_pkg::TGT_W-1:0]           o_write_target,
    output logic [whm_pkg::HOURS_W-1:0]         o_write_value,
    output logic [whm_pkg::CHK_W-1:0]           o_write_check,
    output logic [whm_pkg::HOURS_W-1:0]         o_system_hours_shown,
    output logic [whm_pkg::HOURS_W-1:0]         o_backlight_hours_shown,
    output logic                                o_last_of_run
);
    import whm_pkg::*;

    logic               r_active;
    logic [NSLOT-1:0]   r_rem;
    logic               r_out_valid;
    logic [TGT_W-1:0]   r_target;
    logic [HOURS_W-1:0] r_value;
    logic [CHK_W-1:0]   r_check;
    logic [HOURS_W-1:0] r_sys_shown;
    logic [HOURS_W-1:0] r_bl_shown;
    logic               r_last;

    logic               n_active;
    logic [NSLOT-1:0]   n_rem;
    logic [NSLOT-1:0]   rem;
    logic [NSLOT-1:0]   sel;
    logic [NSLOT-1:0]   left;
    logic               load;
    logic [TGT_W-1:0]   tgt;
    logic [HOURS_W-1:0] value;
    logic [CHK_W-1:0]   check;

    // pending writes of the head request; lowest slot goes first
    assign rem  = r_active ? r_rem : i_job.due;
    assign sel  = rem & (~rem + 1'b1);
    assign left = rem & ~sel;
    assign load = !i_queue_empty && (!r_out_valid || i_ready);
    assign o_pop = load && (left == '0);

    // select the write for the chosen slot
    always_comb begin
        tgt   = TGT_NONE;
        value = '0;
        check = '0;
        unique case (sel)
            4'b0001: begin
                tgt   = TGT_SYS_HOURS;
                value = i_job.sys_hr;
                check = i_job.clr ? CLEAR_CHECK : check_of(i_job.sys_hr);
            end
            4'b0010: begin
                tgt   = TGT_SYS_EIGHTH;
                value = {{(HOURS_W-8){1'b0}}, i_job.sys_min[MINS_W-1:3]};
            end
            4'b0100: begin
                tgt   = TGT_BL_HOURS;
                value = i_job.bl_hr;
                check = i_job.clr ? CLEAR_CHECK : check_of(i_job.bl_hr);
            end
            4'b1000: begin
                tgt   = TGT_BL_EIGHTH;
                value = {{(HOURS_W-8){1'b0}}, i_job.bl_min[MINS_W-1:3]};
            end
            default: begin
                tgt = TGT_NONE;
            end
        endcase
    end

    // track the request in progress
    always_comb begin
        n_active = r_active;
        n_rem    = r_rem;
        if (load) begin
            n_active = (left != '0);
            n_rem    = left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_rem    <= n_rem;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_target    <= tgt;
            r_value     <= value;
            r_check     <= check;
            r_sys_shown <= i_job.sys_hr + {{(HOURS_W-6){1'b0}}, div60(i_job.sys_min)};
            r_bl_shown  <= i_job.bl_hr + {{(HOURS_W-6){1'b0}}, div60(i_job.bl_min)};
            r_last      <= (left == '0);
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_write_target          = r_target;
    assign o_write_value           = r_value;
    assign o_write_check           = r_check;
    assign o_system_hours_shown    = r_sys_shown;
    assign o_backlight_hours_shown = r_bl_shown;
    assign o_last_of_run           = r_last;

`ifndef SYNTHESIS
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_target == TGT_NONE) |-> r_last)
        else $error("empty result not marked last");

    a_check_on_hours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_target == TGT_SYS_EIGHTH || r_target == TGT_BL_EIGHTH
                         || r_target == TGT_NONE)) |-> (r_check == '0))
        else $error("check byte on a non-hours write");

    a_active_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem != '0))
        else $error("request in progress with nothing pending");
`endif

endmodule

`default_nettype wire

>>> design/working_hours_meter.sv
// Top level: saved-value registers, front end, request queue and back end.
// An accepted request is held in the request queue; its first result is registered in the back end.
// Throughput: one result per cycle while the output is not stalled, one result per
// write that a request causes (a single empty result when none is due).
// The front end takes a new request every cycle while the request queue has room.
// Reset (synchronous, active low) clears both meters, the queue and the registers.
`timescale 1ns / 1ps
`default_nettype none

module working_hours_meter #(
    parameter int unsigned QUEUE_DEPTH = whm_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_action,
    input  wire logic                           i_backlight_on,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [whm_pkg::TGT_W-1:0]           o_write_target,
    output logic [whm_pkg::HOURS_W-1:0]         o_write_value,
    output logic [whm_pkg::CHK_W-1:0]           o_write_check,
    output logic [whm_pkg::HOURS_W-1:0]         o_system_hours_shown,
    output logic [whm_pkg::HOURS_W-1:0]         o_backlight_hours_shown,
    output logic                                o_last_of_run,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [4:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import whm_pkg::*;

    t_saved r_saved;
    t_job   front_job;
    t_job   head_job;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    logic   wr_en;
    t_reg   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg'(paddr[4:2]);

    // write the saved-value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYS_HOURS:  r_saved.sys_hr      <= pwdata;
                REG_SYS_CHECK:  r_saved.sys_check   <= pwdata[7:0];
                REG_SYS_EIGHTH: r_saved.sys_eighths <= pwdata[7:0];
                REG_BL_HOURS:   r_saved.bl_hr       <= pwdata;
                REG_BL_CHECK:   r_saved.bl_check    <= pwdata[7:0];
                REG_BL_EIGHTH:  r_saved.bl_eighths  <= pwdata[7:0];
                default:        r_saved <= r_saved;
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_SYS_HOURS:  prdata = r_saved.sys_hr;
            REG_SYS_CHECK:  prdata = {24'd0, r_saved.sys_check};
            REG_SYS_EIGHTH: prdata = {24'd0, r_saved.sys_eighths};
            REG_BL_HOURS:   prdata = r_saved.bl_hr;
            REG_BL_CHECK:   prdata = {24'd0, r_saved.bl_check};
            REG_BL_EIGHTH:  prdata = {24'd0, r_saved.bl_eighths};
            default:        prdata = '0;
        endcase
    end

    whm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_backlight_on (i_backlight_on),
        .i_saved        (r_saved),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_job          (front_job)
    );

    whm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    whm_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_job                   (head_job),
        .i_queue_empty           (q_empty),
        .o_pop                   (pop),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_write_target          (o_write_target),
        .o_write_value           (o_write_value),
        .o_write_check           (o_write_check),
        .o_system_hours_shown    (o_system_hours_shown),
        .o_backlight_hours_shown (o_backlight_hours_shown),
        .o_last_of_run           (o_last_of_run)
    );

endmodule

`default_nettype wire
